@@ rtl/tsts_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsts_pkg
// Shared types and constants of the throttle step test sequencer.
// ----------------------------------------------------------------------------
package tsts_pkg;

  localparam int RPM_W    = 14;
  localparam int TIMER_W  = 16;
  localparam int CFGT_W   = 10;
  localparam int TARGET_W = 11;
  localparam int PHASE_W  = 2;
  localparam int KIND_W   = 2;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [RPM_W-1:0] RPM_VALID_MIN = RPM_W'(0);
  localparam logic [RPM_W-1:0] RPM_VALID_MAX = RPM_W'(16383);
  localparam logic [TARGET_W-1:0] TARGET_SAT = TARGET_W'(2047);

  // item kinds
  localparam logic [KIND_W-1:0] KIND_TICK    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_RPM     = 2'd1;
  localparam logic [KIND_W-1:0] KIND_TRIGGER = 2'd2;

  // test phases
  localparam logic [PHASE_W-1:0] PH_IDLE = 2'd0;
  localparam logic [PHASE_W-1:0] PH_WAIT = 2'd1;
  localparam logic [PHASE_W-1:0] PH_RUN  = 2'd2;
  localparam logic [PHASE_W-1:0] PH_DONE = 2'd3;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_START_RPM     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CUTOFF_RPM    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_START_TIMEOUT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_TIMEOUT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INITIAL_TGT   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_THROTTLE_STEP = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_MAX    = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_IDLE_TGT      = 3'd7;

  // reset values of the registers
  localparam logic [RPM_W-1:0]   RST_START_RPM     = RPM_W'(3000);
  localparam logic [RPM_W-1:0]   RST_CUTOFF_RPM    = RPM_W'(12000);
  localparam logic [TIMER_W-1:0] RST_START_TIMEOUT = TIMER_W'(5000);
  localparam logic [TIMER_W-1:0] RST_STEP_TIMEOUT  = TIMER_W'(3000);
  localparam logic [CFGT_W-1:0]  RST_INITIAL_TGT   = CFGT_W'(300);
  localparam logic [CFGT_W-1:0]  RST_THROTTLE_STEP = CFGT_W'(100);
  localparam logic [CFGT_W-1:0]  RST_TARGET_MAX    = CFGT_W'(1000);
  localparam logic [CFGT_W-1:0]  RST_IDLE_TGT      = CFGT_W'(0);

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [RPM_W-1:0]  rpm_value;
  } in_item_t;

  typedef struct packed {
    logic [PHASE_W-1:0]  test_phase;
    logic [TARGET_W-1:0] throttle_target;
  } out_item_t;

  typedef struct packed {
    logic [RPM_W-1:0]   start_rpm;
    logic [RPM_W-1:0]   cutoff_rpm;
    logic [TIMER_W-1:0] start_timeout_ms;
    logic [TIMER_W-1:0] step_timeout_ms;
    logic [CFGT_W-1:0]  initial_target;
    logic [CFGT_W-1:0]  throttle_step;
    logic [CFGT_W-1:0]  target_max;
    logic [CFGT_W-1:0]  idle_target;
  } cfg_t;

endpackage

@@ rtl/tsts_cfg_regs.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsts_cfg_regs
// Configuration register file, written through a plain indexed write port.
// ----------------------------------------------------------------------------
module tsts_cfg_regs (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_wr_en,
  input  logic [tsts_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [tsts_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  output tsts_pkg::cfg_t                   cfg
);

  tsts_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_rpm        <= tsts_pkg::RST_START_RPM;
      cfg_r.cutoff_rpm       <= tsts_pkg::RST_CUTOFF_RPM;
      cfg_r.start_timeout_ms <= tsts_pkg::RST_START_TIMEOUT;
      cfg_r.step_timeout_ms  <= tsts_pkg::RST_STEP_TIMEOUT;
      cfg_r.initial_target   <= tsts_pkg::RST_INITIAL_TGT;
      cfg_r.throttle_step    <= tsts_pkg::RST_THROTTLE_STEP;
      cfg_r.target_max       <= tsts_pkg::RST_TARGET_MAX;
      cfg_r.idle_target      <= tsts_pkg::RST_IDLE_TGT;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        tsts_pkg::REG_START_RPM:     cfg_r.start_rpm <= cfg_wdata[tsts_pkg::RPM_W-1:0];
        tsts_pkg::REG_CUTOFF_RPM:    cfg_r.cutoff_rpm <= cfg_wdata[tsts_pkg::RPM_W-1:0];
        tsts_pkg::REG_START_TIMEOUT: cfg_r.start_timeout_ms <= cfg_wdata;
        tsts_pkg::REG_STEP_TIMEOUT:  cfg_r.step_timeout_ms <= cfg_wdata;
        tsts_pkg::REG_INITIAL_TGT:   cfg_r.initial_target <= cfg_wdata[tsts_pkg::CFGT_W-1:0];
        tsts_pkg::REG_THROTTLE_STEP: cfg_r.throttle_step <= cfg_wdata[tsts_pkg::CFGT_W-1:0];
        tsts_pkg::REG_TARGET_MAX:    cfg_r.target_max <= cfg_wdata[tsts_pkg::CFGT_W-1:0];
        tsts_pkg::REG_IDLE_TGT:      cfg_r.idle_target <= cfg_wdata[tsts_pkg::CFGT_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

@@ rtl/tsts_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsts_core
// Test state, timers and phase machine; handles one item when go is high
// and presents the result of that item.
// ----------------------------------------------------------------------------
module tsts_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                go,
  input  tsts_pkg::in_item_t  item,
  input  tsts_pkg::cfg_t      cfg,
  output tsts_pkg::out_item_t result
);

  logic [tsts_pkg::PHASE_W-1:0]  phase_r,    phase_nxt;
  logic [tsts_pkg::RPM_W-1:0]    rpm_r,      rpm_nxt;
  logic                          fresh_r,    fresh_nxt;
  logic [tsts_pkg::TARGET_W-1:0] cur_tgt_r,  cur_tgt_nxt;
  logic [tsts_pkg::TARGET_W-1:0] next_tgt_r, next_tgt_nxt;
  logic [tsts_pkg::TIMER_W-1:0]  start_cd_r, start_cd_nxt;
  logic [tsts_pkg::TIMER_W-1:0]  step_cd_r,  step_cd_nxt;

  logic [tsts_pkg::TIMER_W-1:0]  start_cd_dec, step_cd_dec;
  logic [tsts_pkg::TARGET_W:0]   tgt_sum;
  logic [tsts_pkg::TARGET_W-1:0] tgt_sat;
  logic [tsts_pkg::TARGET_W-1:0] idle_tgt, init_tgt;
  logic                          rpm_ok;

  assign start_cd_dec = (start_cd_r != '0) ? start_cd_r - 1'b1 : start_cd_r;
  assign step_cd_dec  = (step_cd_r != '0) ? step_cd_r - 1'b1 : step_cd_r;
  assign tgt_sum = {1'b0, next_tgt_r} + (tsts_pkg::TARGET_W + 1)'(cfg.throttle_step);
  assign tgt_sat = (tgt_sum > {1'b0, tsts_pkg::TARGET_SAT}) ? tsts_pkg::TARGET_SAT
                                                          : tgt_sum[tsts_pkg::TARGET_W-1:0];
  assign idle_tgt = tsts_pkg::TARGET_W'(cfg.idle_target);
  assign init_tgt = tsts_pkg::TARGET_W'(cfg.initial_target);
  assign rpm_ok = (item.rpm_value >= tsts_pkg::RPM_VALID_MIN) &&
                  (item.rpm_value <= tsts_pkg::RPM_VALID_MAX);

  always_comb begin
    phase_nxt    = phase_r;
    rpm_nxt      = rpm_r;
    fresh_nxt    = fresh_r;
    cur_tgt_nxt  = cur_tgt_r;
    next_tgt_nxt = next_tgt_r;
    start_cd_nxt = start_cd_r;
    step_cd_nxt  = step_cd_r;
    case (item.kind)
      tsts_pkg::KIND_TICK: begin
        start_cd_nxt = start_cd_dec;
        step_cd_nxt  = step_cd_dec;
        unique case (phase_r)
          tsts_pkg::PH_IDLE: ;
          tsts_pkg::PH_WAIT: begin
            if (start_cd_dec == '0) begin
              phase_nxt = tsts_pkg::PH_DONE;
            end else if (fresh_r && (rpm_r <= cfg.start_rpm)) begin
              fresh_nxt   = 1'b0;
              step_cd_nxt = cfg.step_timeout_ms;
              cur_tgt_nxt = next_tgt_r;
              phase_nxt   = tsts_pkg::PH_RUN;
            end else begin
              cur_tgt_nxt = idle_tgt;
            end
          end
          tsts_pkg::PH_RUN: begin
            if ((step_cd_dec == '0) || (rpm_r >= cfg.cutoff_rpm)) begin
              cur_tgt_nxt = idle_tgt;
              if (next_tgt_r < tsts_pkg::TARGET_W'(cfg.target_max)) begin
                next_tgt_nxt = tgt_sat;
                start_cd_nxt = cfg.start_timeout_ms;
                phase_nxt    = tsts_pkg::PH_WAIT;
              end else begin
                phase_nxt = tsts_pkg::PH_DONE;
              end
            end
          end
          default: begin
            cur_tgt_nxt  = idle_tgt;
            next_tgt_nxt = init_tgt;
            phase_nxt    = tsts_pkg::PH_IDLE;
          end
        endcase
      end
      tsts_pkg::KIND_RPM: begin
        if (rpm_ok) begin
          rpm_nxt   = item.rpm_value;
          fresh_nxt = 1'b1;
        end
      end
      tsts_pkg::KIND_TRIGGER: begin
        if (phase_r == tsts_pkg::PH_IDLE) begin
          start_cd_nxt = cfg.start_timeout_ms;
          phase_nxt    = tsts_pkg::PH_WAIT;
        end else begin
          phase_nxt = tsts_pkg::PH_DONE;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= tsts_pkg::PH_IDLE;
      rpm_r      <= '0;
      fresh_r    <= 1'b0;
      cur_tgt_r  <= tsts_pkg::TARGET_W'(tsts_pkg::RST_IDLE_TGT);
      next_tgt_r <= tsts_pkg::TARGET_W'(tsts_pkg::RST_INITIAL_TGT);
      start_cd_r <= '0;
      step_cd_r  <= '0;
    end else if (go) begin
      phase_r    <= phase_nxt;
      rpm_r      <= rpm_nxt;
      fresh_r    <= fresh_nxt;
      cur_tgt_r  <= cur_tgt_nxt;
      next_tgt_r <= next_tgt_nxt;
      start_cd_r <= start_cd_nxt;
      step_cd_r  <= step_cd_nxt;
    end
  end

  assign result.test_phase      = phase_nxt;
  assign result.throttle_target = cur_tgt_nxt;

endmodule

@@ rtl/throttle_step_test_sequencer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// throttle_step_test_sequencer
// Stepped throttle test sequencer: ticks, rpm reports and triggers in,
// one phase and throttle target result out for every item.
// ----------------------------------------------------------------------------
// path: an accepted item is caught in the input register, then the phase
//   logic writes its result into the result register
// throughput: one item per cycle, bounded only by out_stall
// reset (synchronous, rst_n low): config and core registers back to defaults, phase idle,
//   both pipeline stages empty
module throttle_step_test_sequencer (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  tsts_pkg::in_item_t               in_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output tsts_pkg::out_item_t              out_data,
  input  logic                             cfg_wr_en,
  input  logic [tsts_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [tsts_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  tsts_pkg::cfg_t      cfg;
  tsts_pkg::in_item_t  in_item_r;
  tsts_pkg::out_item_t out_item_r;
  tsts_pkg::out_item_t result;
  logic                in_vld_r;
  logic                out_vld_r;
  logic                go;
  logic                in_take;

  // item leaves the input register when the result register is free
  assign go       = in_vld_r && (!out_vld_r || !out_stall);
  assign in_stall = in_vld_r && !go;
  assign in_take  = in_valid && !in_stall;

  tsts_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  tsts_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .go     (go),
    .item   (in_item_r),
    .cfg    (cfg),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (in_take) begin
        in_vld_r <= 1'b1;
      end else if (go) begin
        in_vld_r <= 1'b0;
      end
      if (go) begin
        out_vld_r <= 1'b1;
      end else if (!out_stall) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_item_r <= in_data;
    end
    if (go) begin
      out_item_r <= result;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_item_r;

endmodule
